[sv/assert_macros.svh]
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent implication check, disabled in reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication check, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/bjs_pkg.sv]
// ----------------------------------------------------------------------------
// bjs_pkg
// shared constants and command/status types for the batch job scheduler
// ----------------------------------------------------------------------------
package bjs_pkg;

   localparam int MAX_JOBS_DEF = 16;
   localparam int SUM_W        = 20;
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [15:0] SAT16 = 16'hFFFF;

   localparam logic POLICY_FCFS = 1'b0;
   localparam logic POLICY_SJF  = 1'b1;

   localparam logic [0:0] CSR_POLICY = 1'b0;

   typedef struct packed {
      logic load;
      logic scan_init;
      logic scan_step;
      logic sjf_init;
      logic sjf_step;
      logic commit;
      logic div_start;
      logic div_avg;
      logic emit;
      logic clear;
      logic set_time0;
   } cmd_type;

   typedef struct packed {
      logic scan_end;
      logic div_busy;
      logic full;
      logic last_pick;
      logic out_busy;
   } stat_type;

endpackage

[sv/batch_job_scheduler_fcfs_sjf_unit.sv]
// a batch is scheduled after its last word; each result takes a table scan
// (a second one under sjf), commit, a divide and hand-off, plus any wait for
// the prior word; the last result adds the two average divides
// throughput: one job loads per cycle while no batch is being scheduled
// reset: synchronous, clears job count, done flags, sums, time and policy_mode
// ----------------------------------------------------------------------------
// batch_job_scheduler_fcfs_sjf_unit
// non-preemptive fcfs / sjf batch scheduler with apb register port
// ----------------------------------------------------------------------------
module batch_job_scheduler_fcfs_sjf_unit
   import bjs_pkg::*;
#(
   parameter int MAX_JOBS = MAX_JOBS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // job_id, submit_minute, run_length, pad
   input  logic        req_tlast,  // last_job
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [127:0] rsp_tdata, // out_job_id, start_minute, end_minute,
                                   // turnover, weighted_turnover,
                                   // avg_turnover, avg_weighted
   output logic        rsp_tlast,  // last_result
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic     pol_ff;
   cmd_type  cmd;
   stat_type stat;
   logic [127:0] dp_data;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_POLICY) ? {31'd0, pol_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pol_ff <= POLICY_FCFS;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_POLICY) begin
         pol_ff <= csr_pwdata[0];
      end
   end

   bjs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_last   (req_tlast),
      .policy     (pol_ff),
      .stat       (stat),
      .cmd        (cmd)
   );

   bjs_datapath #(.MAX_JOBS(MAX_JOBS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_id      (req_tdata[7:0]),
      .in_submit  (req_tdata[23:8]),
      .in_len     (req_tdata[33:24]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (dp_data),
      .rsp_tlast  (rsp_tlast)
   );

   // datapath packs id in a byte then skips a byte; close the gap
   assign rsp_tdata = {8'd0, dp_data[127:16], dp_data[7:0]};

endmodule

[sv/bjs_div.sv]
// ----------------------------------------------------------------------------
// bjs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bjs_div
   import bjs_pkg::*;
#(
   parameter int NUM_W = 28,
   parameter int DEN_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quo
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CW-1:0]    n_ff, n_in;
   logic [DEN_W:0]   sh;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      n_in = n_ff;
      sh   = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         n_in = CW'(NUM_W);
      end else if (n_ff != '0) begin
         n_in = n_ff - 1'b1;
         if (sh >= {1'b0, d_ff}) begin
            r_in = sh - {1'b0, d_ff};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
      end else begin
         n_ff <= n_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy = (n_ff != '0);
   assign quo  = q_ff;

endmodule

[sv/bjs_datapath.sv]
// ----------------------------------------------------------------------------
// bjs_datapath
// job table, selection scan, timing arithmetic, divider and output register
// ----------------------------------------------------------------------------
module bjs_datapath
   import bjs_pkg::*;
#(
   parameter int MAX_JOBS = MAX_JOBS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [7:0]  in_id,
   input  logic [15:0] in_submit,
   input  logic [9:0]  in_len,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [127:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CW = $clog2(MAX_JOBS + 1);

   logic [7:0]  ids_ff  [MAX_JOBS];
   logic [15:0] sub_ff  [MAX_JOBS];
   logic [9:0]  len_ff  [MAX_JOBS];
   logic [MAX_JOBS-1:0] done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [15:0] now_ff, now_in;
   logic [SUM_W-1:0] tsum_ff, tsum_in, wsum_ff, wsum_in;
   logic [IW-1:0] idx_ff, idx_in, best_ff, best_in;
   logic          have_ff, have_in;
   logic [CW-1:0] left_ff, left_in;
   logic          sjf_ff, sjf_in;

   // job under scan and the chosen job
   logic [7:0]  r_id;
   logic [15:0] r_sub, b_sub;
   logic [9:0]  r_len, b_len;
   logic        r_done;

   logic [15:0] st_ff, st_in, en_ff, en_in, tu_ff, tu_in;
   logic [7:0]  oid_ff, oid_in;
   logic [15:0] wt_ff, wt_in;
   logic        lst_ff, lst_in;

   logic [15:0] strt;
   logic [16:0] endsum;
   logic [15:0] endv;
   logic [27:0] dnum, quo;
   logic [9:0]  dden;
   logic        dbusy;
   logic [15:0] q16;

   logic        ov_ff, ov_in;
   logic [127:0] od_ff, od_in;
   logic        ol_ff, ol_in;
   logic [1:0]  avg_ph_ff, avg_ph_in;
   logic [15:0] avg_t_ff, avg_t_in;

   assign r_id   = ids_ff[idx_ff];
   assign r_sub  = sub_ff[idx_ff];
   assign r_len  = len_ff[idx_ff];
   assign r_done = done_ff[idx_ff];
   assign b_sub  = sub_ff[best_ff];
   assign b_len  = len_ff[best_ff];

   // idle gap: start at the submit time when the job arrives after the current time
   assign strt   = (b_sub > now_ff) ? b_sub : now_ff;
   assign endsum = {1'b0, strt} + {7'd0, b_len};
   assign endv   = endsum[16] ? SAT16 : endsum[15:0];
   assign q16    = (quo[27:16] != '0) ? SAT16 : quo[15:0];

   bjs_div #(.NUM_W(28), .DEN_W(10)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (dnum),
      .den   (dden),
      .busy  (dbusy),
      .quo   (quo)
   );

   always_comb begin
      done_in = done_ff; cnt_in = cnt_ff; now_in = now_ff;
      tsum_in = tsum_ff; wsum_in = wsum_ff;
      idx_in = idx_ff; best_in = best_ff; have_in = have_ff;
      left_in = left_ff; sjf_in = sjf_ff;
      st_in = st_ff; en_in = en_ff; tu_in = tu_ff; oid_in = oid_ff;
      wt_in = wt_ff; lst_in = lst_ff;
      ov_in = ov_ff; od_in = od_ff; ol_in = ol_ff;
      avg_ph_in = avg_ph_ff; avg_t_in = avg_t_ff;
      dnum = {4'd0, tu_ff, 8'd0};
      dden = (b_len == '0) ? 10'd1 : b_len;

      if (ov_ff && rsp_tready) ov_in = 1'b0;

      if (cmd.load && cnt_ff < CW'(MAX_JOBS)) begin
         cnt_in = cnt_ff + 1'b1;
         done_in[cnt_ff[IW-1:0]] = 1'b0;
      end
      if (cmd.set_time0) begin
         now_in  = sub_ff[0];
         left_in = cnt_ff;
      end
      if (cmd.scan_init) begin
         idx_in = '0; have_in = 1'b0; sjf_in = 1'b0;
      end
      if (cmd.sjf_init) begin
         idx_in = '0; have_in = 1'b0; sjf_in = 1'b1;
         if (b_sub > now_ff) now_in = b_sub;
      end
      if (cmd.scan_step) begin
         if (CW'(idx_ff) < cnt_ff && !r_done) begin
            if (!sjf_ff) begin
               if (!have_ff || r_sub < b_sub) begin
                  best_in = idx_ff; have_in = 1'b1;
               end
            end else if (r_sub <= now_ff && (!have_ff || r_len < b_len)) begin
               best_in = idx_ff; have_in = 1'b1;
            end
         end
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.commit) begin
         st_in  = strt;
         en_in  = endv;
         tu_in  = endv - b_sub;
         oid_in = ids_ff[best_ff];
         lst_in = (left_ff == CW'(1));
         done_in[best_ff] = 1'b1;
         now_in  = endv;
         left_in = left_ff - 1'b1;
      end
      if (cmd.div_avg) begin
         if (avg_ph_ff == 2'd1) begin
            dnum = {tsum_ff, 8'd0};
         end else begin
            dnum = {8'd0, wsum_ff};
         end
         dden = {{(10-CW){1'b0}}, cnt_ff};
      end
      if (cmd.emit) begin
         unique case (avg_ph_ff)
            2'd0: begin
               wt_in = q16;
               tsum_in = ({1'b0, tsum_ff} + {5'd0, tu_ff} > {1'b0, SUM_MAX})
                  ? SUM_MAX : tsum_ff + {4'd0, tu_ff};
               wsum_in = ({1'b0, wsum_ff} + {5'd0, q16} > {1'b0, SUM_MAX})
                  ? SUM_MAX : wsum_ff + {4'd0, q16};
               if (lst_ff) begin
                  avg_ph_in = 2'd1;
               end else begin
                  ov_in = 1'b1; ol_in = 1'b0;
                  od_in = {32'd0, q16, tu_ff, en_ff, st_ff, 8'd0, oid_ff};
               end
            end
            2'd1: begin
               avg_t_in = q16; avg_ph_in = 2'd2;
            end
            2'd2: begin
               ov_in = 1'b1; ol_in = 1'b1; avg_ph_in = 2'd0;
               od_in = {q16, avg_t_ff, wt_ff, tu_ff, en_ff, st_ff, 8'd0, oid_ff};
            end
            default: avg_ph_in = 2'd0;
         endcase
      end
      if (cmd.clear) begin
         done_in = '0; cnt_in = '0; now_in = '0; tsum_in = '0; wsum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0; cnt_ff <= '0; now_ff <= '0;
         tsum_ff <= '0; wsum_ff <= '0; ov_ff <= 1'b0; avg_ph_ff <= '0;
         left_ff <= '0; have_ff <= 1'b0; sjf_ff <= 1'b0;
      end else begin
         done_ff <= done_in; cnt_ff <= cnt_in; now_ff <= now_in;
         tsum_ff <= tsum_in; wsum_ff <= wsum_in; ov_ff <= ov_in;
         avg_ph_ff <= avg_ph_in; left_ff <= left_in; have_ff <= have_in;
         sjf_ff <= sjf_in;
      end
      if (cmd.load && cnt_ff < CW'(MAX_JOBS)) begin
         ids_ff[cnt_ff[IW-1:0]] <= in_id;
         sub_ff[cnt_ff[IW-1:0]] <= in_submit;
         len_ff[cnt_ff[IW-1:0]] <= in_len;
      end
      idx_ff <= idx_in; best_ff <= best_in;
      st_ff <= st_in; en_ff <= en_in; tu_ff <= tu_in; oid_ff <= oid_in;
      wt_ff <= wt_in; lst_ff <= lst_in; od_ff <= od_in; ol_ff <= ol_in;
      avg_t_ff <= avg_t_in;
   end

   assign stat.scan_end  = (CW'(idx_ff) >= cnt_ff - 1'b1) || (idx_ff == IW'(MAX_JOBS-1));
   assign stat.div_busy  = dbusy;
   assign stat.full      = (cnt_ff == CW'(MAX_JOBS));
   assign stat.last_pick = lst_ff && (avg_ph_ff != 2'd0);
   assign stat.out_busy  = ov_ff;

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tlast  = ol_ff;

endmodule

[sv/bjs_ctrl.sv]
// ----------------------------------------------------------------------------
// bjs_ctrl
// sequencer for load, pick scans, division and result hand-off
// ----------------------------------------------------------------------------
module bjs_ctrl
   import bjs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic     req_last,
   input  logic     policy,
   input  stat_type stat,
   output cmd_type  cmd
);
   `include "assert_macros.svh"

   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_TIME  = 4'd1;
   localparam logic [3:0] S_SCAN1 = 4'd2;
   localparam logic [3:0] S_SJF0  = 4'd3;
   localparam logic [3:0] S_SCAN2 = 4'd4;
   localparam logic [3:0] S_COMMIT= 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_WAIT  = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;
   localparam logic [3:0] S_AVG   = 4'd9;
   localparam logic [3:0] S_AWAIT = 4'd10;
   localparam logic [3:0] S_AEMIT = 4'd11;
   localparam logic [3:0] S_CLEAR = 4'd12;

   logic [3:0] st_ff, st_in;
   logic [1:0] avn_ff, avn_in;
   logic       lp_ff, lp_in;
   logic       pol_ff, pol_in;

   assign req_tready = (st_ff == S_LOAD);

   always_comb begin
      st_in = st_ff; avn_in = avn_ff; lp_in = lp_ff; pol_in = pol_ff;
      cmd = '0;
      unique case (st_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_last) st_in = S_TIME;
            end
         end
         S_TIME: begin
            cmd.set_time0 = 1'b1; cmd.scan_init = 1'b1;
            pol_in = policy; st_in = S_SCAN1;
         end
         S_SCAN1: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_end) st_in = pol_ff ? S_SJF0 : S_COMMIT;
         end
         S_SJF0: begin
            cmd.sjf_init = 1'b1; st_in = S_SCAN2;
         end
         S_SCAN2: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_end) st_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1; st_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_start = 1'b1; st_in = S_WAIT;
         end
         S_WAIT: begin
            if (!stat.div_busy && !stat.out_busy) st_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            st_in = S_CLEAR;
         end
         S_AVG: begin
            cmd.div_avg = 1'b1; cmd.div_start = 1'b1; st_in = S_AWAIT;
         end
         S_AWAIT: begin
            cmd.div_avg = 1'b1;
            if (!stat.div_busy && !stat.out_busy) st_in = S_AEMIT;
         end
         S_AEMIT: begin
            cmd.emit = 1'b1; cmd.div_avg = 1'b1;
            avn_in = avn_ff + 1'b1;
            st_in = (avn_ff == 2'd0) ? S_AVG : S_CLEAR;
         end
         S_CLEAR: begin
            // decide: next pick, averages, or batch end
            if (lp_ff) begin
               cmd.clear = 1'b1; lp_in = 1'b0; avn_in = '0; st_in = S_LOAD;
            end else if (stat.last_pick) begin
               lp_in = 1'b1; st_in = S_AVG;
            end else begin
               cmd.scan_init = 1'b1; st_in = S_SCAN1;
            end
         end
         default: st_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOAD; avn_ff <= '0; lp_ff <= 1'b0; pol_ff <= 1'b0;
      end else begin
         st_ff <= st_in; avn_ff <= avn_in; lp_ff <= lp_in; pol_ff <= pol_in;
      end
   end

   `ASSERT_IMPL(a_ready_load, clock, reset, req_tready, st_ff == S_LOAD, "ready outside load")
   `ASSERT_NEXT(a_emit_clear, clock, reset, st_ff == S_EMIT, st_ff == S_CLEAR, "emit sequence")
   `ASSERT_NEXT(a_commit_div, clock, reset, cmd.commit, cmd.div_start, "commit without divide")

endmodule
